// ===== sv/tcd_pkg.sv =====
// ----------------------------------------------------------------------------
// tcd_pkg
// shared types, codes and constants of the tile change detector
// ----------------------------------------------------------------------------
package tcd_pkg;

  // default screen geometry
  localparam int TILES_ACROSS_DEF = 16;
  localparam int TILES_DOWN_DEF   = 12;
  localparam int TILE_SIZE_DEF    = 64;

  // fnv-1a 32-bit constants
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

  // row coordinates saturate here
  localparam int ROW_MAX = 1023;

  typedef enum logic [1:0] {
    FUNC_SAMPLE   = 2'd0,
    FUNC_MARK_ALL = 2'd1,
    FUNC_TRIM     = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  tile_index;
    logic [31:0] pixel;
    logic        last_sample;
    logic [9:0]  new_top;
  } tcd_in_t;

  typedef struct packed {
    logic        tile_changed;
    logic [31:0] tile_digest;
    logic [9:0]  span_top;
    logic [9:0]  span_bottom;
  } tcd_out_t;

  // request to overwrite the whole hash store
  typedef struct packed {
    logic start;
    logic fill_ones;
  } tcd_sweep_t;

endpackage

// ===== sv/tcd_store.sv =====
// ----------------------------------------------------------------------------
// tcd_store
// per-tile hash memory with one read and one write port, read-after-write
// forwarding and a fill sweep used after reset, mark-all and clear
// ----------------------------------------------------------------------------
module tcd_store #(
  parameter int NUM_TILES = tcd_pkg::TILES_ACROSS_DEF * tcd_pkg::TILES_DOWN_DEF,
  parameter int ADDR_W    = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [31:0]         rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [31:0]         wr_data,
  input  tcd_pkg::tcd_sweep_t sweep,
  output logic                busy
);
  import tcd_pkg::*;

  logic [31:0]       mem [NUM_TILES];
  logic [31:0]       mem_q;
  logic              fwd;
  logic [31:0]       fwd_data;
  logic [ADDR_W-1:0] sweep_addr;
  logic [31:0]       fill_word;

  // sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      sweep_addr <= '0;
      fill_word  <= '0;
    end else if (sweep.start) begin
      busy       <= 1'b1;
      sweep_addr <= '0;
      fill_word  <= sweep.fill_ones ? ALL_ONES : '0;
    end else if (busy) begin
      if (sweep_addr == ADDR_W'(NUM_TILES - 1)) begin
        busy <= 1'b0;
      end
      sweep_addr <= sweep_addr + ADDR_W'(1);
    end
  end

  // memory array
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep_addr] <= fill_word;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd      <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  // a write landing on the same edge as the read wins
  assign rd_data = fwd ? fwd_data : mem_q;

endmodule

// ===== sv/tile_change_detector.sv =====
// ----------------------------------------------------------------------------
// tile_change_detector
// fnv-1a tile hashing with per-tile change detection and a dirty row span
// ----------------------------------------------------------------------------
//
//  channel  valid      stall      payload    beat
//  input    in_valid   in_stall   in_data    one command or pixel sample
//  output   out_valid  out_stall  out_data   one result (none for bad tile)
//
//  sample beats are taken one per cycle while in_stall is low; results are registered
//  mark-all and clear hold in_stall high while the op sits in the compare stage
//  and then while the fill sweep writes every store entry
//  after reset the same sweep clears the store, with in_stall held high
//  a stalled output holds the whole pipe; at most one beat waits in the
//  compare stage and one in the output register
//
module tile_change_detector #(
  parameter int TILES_ACROSS = tcd_pkg::TILES_ACROSS_DEF,
  parameter int TILES_DOWN   = tcd_pkg::TILES_DOWN_DEF,
  parameter int TILE_SIZE    = tcd_pkg::TILE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcd_pkg::tcd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tcd_pkg::tcd_out_t out_data
);
  import tcd_pkg::*;

  localparam int NUM_TILES  = TILES_ACROSS * TILES_DOWN;
  localparam int ADDR_W     = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
  // reciprocal for tile row = index / TILES_ACROSS, exact for 8-bit indices
  localparam int TY_MUL     = (65536 + TILES_ACROSS - 1) / TILES_ACROSS;
  localparam int SCREEN_ROWS = TILES_DOWN * TILE_SIZE;
  localparam logic [9:0] SCREEN_BOTTOM =
    (SCREEN_ROWS > ROW_MAX) ? 10'(ROW_MAX) : 10'(SCREEN_ROWS);

  // ---------------------------------------------------------------------------
  // input stage: hash fold and store read
  // ---------------------------------------------------------------------------
  logic        accept;
  logic        adv;          // compare stage may move on
  logic        hold_op;      // store-wide op in compare stage
  logic        busy;
  logic        in_range;
  logic        is_sample;
  logic [31:0] running_hash;
  logic [31:0] hash_mix;
  logic [24:0] ty_prod;

  // compare stage registers
  logic              s1_valid;
  func_t             s1_func;
  logic              s1_last;
  logic [31:0]       s1_digest;
  logic [ADDR_W-1:0] s1_addr;
  logic [7:0]        s1_ty;
  logic [9:0]        s1_new_top;

  // dirty span
  logic [9:0] dirty_top;
  logic [9:0] dirty_bottom;
  logic [9:0] top_next;
  logic [9:0] bottom_next;

  logic        rd_en;
  logic [31:0] rd_data;
  logic        changed;
  logic        wr_en;
  tcd_sweep_t  sweep;

  assign adv       = !(out_valid && out_stall);
  assign hold_op   = s1_valid && ((s1_func == FUNC_MARK_ALL) || (s1_func == FUNC_CLEAR));
  assign in_stall  = !adv || busy || hold_op;
  assign accept    = in_valid && !in_stall;
  assign is_sample = (in_data.func == FUNC_SAMPLE);
  assign in_range  = 32'(in_data.tile_index) < 32'(NUM_TILES);

  // one constant multiply per sample
  assign hash_mix = (running_hash ^ in_data.pixel) * FNV_PRIME;
  assign ty_prod  = 25'(in_data.tile_index) * 25'(TY_MUL);

  // stored hash only matters on the tile's last sample
  assign rd_en = accept && is_sample && in_range && in_data.last_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
    end else if (accept) begin
      case (in_data.func)
        FUNC_SAMPLE: begin
          if (in_range) begin
            running_hash <= in_data.last_sample ? FNV_BASIS : hash_mix;
          end
        end
        FUNC_CLEAR: running_hash <= FNV_BASIS;
        default:    running_hash <= running_hash;
      endcase
    end
  end

  // out-of-range samples vanish here and yield no result
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept && !(is_sample && !in_range);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func    <= in_data.func;
      s1_last    <= in_data.last_sample;
      s1_digest  <= hash_mix;
      s1_addr    <= ADDR_W'(in_data.tile_index);
      s1_ty      <= ty_prod[23:16];
      s1_new_top <= in_data.new_top;
    end
  end

  // ---------------------------------------------------------------------------
  // compare stage: hash compare, store write-back, span update
  // ---------------------------------------------------------------------------
  logic [16:0] y0_full;
  logic [16:0] y1_full;
  logic [9:0]  y0;
  logic [9:0]  y1;
  logic        finished;

  assign finished = (s1_func == FUNC_SAMPLE) && s1_last;
  assign changed  = finished && (s1_digest != rd_data);

  // rows covered by the tile, saturated
  assign y0_full = 17'(s1_ty) * 17'(TILE_SIZE);
  assign y1_full = y0_full + 17'(TILE_SIZE);
  assign y0 = (y0_full > 17'(ROW_MAX)) ? 10'(ROW_MAX) : y0_full[9:0];
  assign y1 = (y1_full > 17'(ROW_MAX)) ? 10'(ROW_MAX) : y1_full[9:0];

  always_comb begin
    top_next    = dirty_top;
    bottom_next = dirty_bottom;
    case (s1_func)
      FUNC_SAMPLE: begin
        if (changed) begin
          if (dirty_bottom <= dirty_top) begin
            // empty span restarts at this tile
            top_next    = y0;
            bottom_next = y1;
          end else begin
            if (y0 < dirty_top)    top_next    = y0;
            if (y1 > dirty_bottom) bottom_next = y1;
          end
        end
      end
      FUNC_MARK_ALL: begin
        top_next    = '0;
        bottom_next = SCREEN_BOTTOM;
      end
      FUNC_TRIM: begin
        if ((dirty_bottom <= dirty_top) || (s1_new_top >= dirty_bottom)) begin
          // everything sent
          top_next    = '0;
          bottom_next = '0;
        end else if (s1_new_top > dirty_top) begin
          top_next = s1_new_top;
        end
      end
      FUNC_CLEAR: begin
        top_next    = '0;
        bottom_next = '0;
      end
      default: begin
        top_next    = dirty_top;
        bottom_next = dirty_bottom;
      end
    endcase
  end

  assign wr_en = s1_valid && adv && changed;

  // store-wide ops start the fill sweep as they leave the compare stage
  assign sweep.start     = hold_op && adv;
  assign sweep.fill_ones = (s1_func == FUNC_MARK_ALL);

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty_top    <= '0;
      dirty_bottom <= '0;
    end else if (s1_valid && adv) begin
      dirty_top    <= top_next;
      dirty_bottom <= bottom_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      out_data.tile_changed <= changed;
      out_data.tile_digest  <= finished ? s1_digest : '0;
      out_data.span_top     <= top_next;
      out_data.span_bottom  <= bottom_next;
    end
  end

  // ---------------------------------------------------------------------------
  // hash store
  // ---------------------------------------------------------------------------
  tcd_store #(
    .NUM_TILES (NUM_TILES),
    .ADDR_W    (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (ADDR_W'(in_data.tile_index)),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (s1_digest),
    .sweep   (sweep),
    .busy    (busy)
  );

endmodule

// ===== bench/tb_tile_change_detector.sv =====
// ----------------------------------------------------------------------------
// tb_tile_change_detector
// self-checking bench: a queued beat driver, a result monitor and a
// beat-level predictor of the hash store, running fnv-1a hash and dirty span
// ----------------------------------------------------------------------------
//
// the beat list is built up front: a short directed part hits both tile
// corners, ignored tile numbers, every trim outcome, mark-all and session
// clear; the random part is mostly whole tiles (a few samples, the last one
// flagged) with pixel patterns that repeat per tile so that unchanged tiles
// show up, mixed with span trims, sweeps and stray samples that break a tile
// open. each accepted beat runs through the predictor, each accepted result
// is compared against the oldest prediction.
//
module tb_tile_change_detector;
  import tcd_pkg::*;

  // geometry as built into the block
  localparam int NUM_TILES   = TILES_ACROSS_DEF * TILES_DOWN_DEF;
  localparam int SCREEN_ROWS = (TILES_DOWN_DEF * TILE_SIZE_DEF > ROW_MAX) ?
                               ROW_MAX : TILES_DOWN_DEF * TILE_SIZE_DEF;

  // run shape
  localparam int RANDOM_BEATS = 950;
  localparam int IDLE_PCT     = 26;
  localparam int CALM_FROM    = 3000;    // no idling on either side in here
  localparam int CALM_TO      = 4500;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_CAP    = 40;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  tcd_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tcd_out_t out_data;

  tile_change_detector DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // beats waiting for the driver, and results the block still owes
  tcd_in_t  beat_plan[$];
  tcd_out_t digest_due[$];
  int       beats_planned;
  int       beats_taken;
  int       mismatches;
  int       cycle_count;
  logic     in_fire;

  // predictor state
  logic [31:0] stored_hash[NUM_TILES];
  logic [31:0] fold_hash;
  logic [9:0]  span_lo;
  logic [9:0]  span_hi;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [9:0] clamp_row(input int row);
    return (row > ROW_MAX) ? 10'(ROW_MAX) : 10'(row);
  endfunction

  task automatic clear_store(input logic [31:0] fill);
    for (int i = 0; i < NUM_TILES; i++) stored_hash[i] = fill;
  endtask

  task automatic fold_beat(input tcd_in_t b);
    tcd_out_t res;
    int       band;
    logic [9:0] y0;
    logic [9:0] y1;
    res = '0;
    case (b.func)
      FUNC_SAMPLE: begin
        // tiles past the screen are dropped without a result
        if (b.tile_index >= NUM_TILES) return;
        fold_hash = (fold_hash ^ b.pixel) * FNV_PRIME;
        if (b.last_sample) begin
          res.tile_digest = fold_hash;
          if (fold_hash != stored_hash[b.tile_index]) begin
            res.tile_changed = 1'b1;
            stored_hash[b.tile_index] = fold_hash;
            band = b.tile_index / TILES_ACROSS_DEF;
            y0 = clamp_row(band * TILE_SIZE_DEF);
            y1 = clamp_row(band * TILE_SIZE_DEF + TILE_SIZE_DEF);
            // an empty span restarts at this tile's rows, else it grows
            if (span_hi <= span_lo) begin
              span_lo = y0;
              span_hi = y1;
            end else begin
              if (y0 < span_lo) span_lo = y0;
              if (y1 > span_hi) span_hi = y1;
            end
          end
          fold_hash = FNV_BASIS;
        end
      end
      FUNC_MARK_ALL: begin
        // running hash survives a mark-all
        clear_store(ALL_ONES);
        span_lo = '0;
        span_hi = 10'(SCREEN_ROWS);
      end
      FUNC_TRIM: begin
        if (span_hi <= span_lo || b.new_top >= span_hi) begin
          span_lo = '0;
          span_hi = '0;
        end else if (b.new_top > span_lo) begin
          span_lo = b.new_top;
        end
      end
      default: begin
        clear_store('0);
        span_lo = '0;
        span_hi = '0;
        fold_hash = FNV_BASIS;
      end
    endcase
    res.span_top = span_lo;
    res.span_bottom = span_hi;
    digest_due.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input tcd_out_t got);
    tcd_out_t want;
    if (digest_due.size() == 0) begin
      report_mismatch("result beat with nothing owed, digest", got.tile_digest, '0);
      return;
    end
    want = digest_due.pop_front();
    if (got.tile_changed !== want.tile_changed)
      report_mismatch("tile_changed", 32'(got.tile_changed), 32'(want.tile_changed));
    if (got.tile_digest !== want.tile_digest)
      report_mismatch("tile_digest", got.tile_digest, want.tile_digest);
    if (got.span_top !== want.span_top)
      report_mismatch("span_top", 32'(got.span_top), 32'(want.span_top));
    if (got.span_bottom !== want.span_bottom)
      report_mismatch("span_bottom", 32'(got.span_bottom), 32'(want.span_bottom));
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  function automatic void queue_beat(input func_t f, input logic [7:0] tile,
                                     input logic [31:0] px, input logic last,
                                     input logic [9:0] top);
    tcd_in_t b;
    b.func = f;
    b.tile_index = tile;
    b.pixel = px;
    b.last_sample = last;
    b.new_top = top;
    beat_plan.push_back(b);
  endfunction

  // command beats carry random junk in the fields they do not use
  function automatic void queue_cmd(input func_t f, input logic [9:0] top);
    queue_beat(f, 8'($urandom), $urandom, 1'($urandom), top);
  endfunction

  task automatic build_directed();
    // first tile, zero pixel: differs from the cleared store
    queue_beat(FUNC_SAMPLE, 8'd0, 32'h0000_0000, 1'b1, '0);
    // same tile again gives the same hash, nothing changes
    queue_beat(FUNC_SAMPLE, 8'd0, 32'h0000_0000, 1'b1, '0);
    // last tile over two samples, the first pixel all ones
    queue_beat(FUNC_SAMPLE, 8'd191, 32'hFFFF_FFFF, 1'b0, 10'h3FF);
    queue_beat(FUNC_SAMPLE, 8'd191, 32'h00FF_FFFF, 1'b1, 10'h3FF);
    // tile numbers past the screen are ignored, even mid-tile
    queue_beat(FUNC_SAMPLE, 8'd40, 32'h0012_3456, 1'b0, '0);
    queue_beat(FUNC_SAMPLE, 8'd192, 32'hDEAD_BEEF, 1'b1, '0);
    queue_beat(FUNC_SAMPLE, 8'd255, 32'hFFFF_FFFF, 1'b1, 10'h3FF);
    queue_beat(FUNC_SAMPLE, 8'd40, 32'h0065_4321, 1'b1, '0);
    // trims: at top does nothing, inside moves top, below does nothing,
    // at the bottom clears, then a trim on the empty span
    queue_cmd(FUNC_TRIM, 10'd0);
    queue_cmd(FUNC_TRIM, 10'd300);
    queue_cmd(FUNC_TRIM, 10'd100);
    queue_cmd(FUNC_TRIM, 10'd768);
    queue_cmd(FUNC_TRIM, 10'd5);
    // mark-all leaves every tile reading as changed
    queue_cmd(FUNC_MARK_ALL, 10'd0);
    queue_beat(FUNC_SAMPLE, 8'd17, 32'h00AB_CDEF, 1'b1, '0);
    queue_cmd(FUNC_TRIM, 10'd767);
    queue_cmd(FUNC_TRIM, 10'd768);
    // mark-all in the middle of a tile keeps the running hash
    queue_beat(FUNC_SAMPLE, 8'd100, 32'h0010_2030, 1'b0, '0);
    queue_cmd(FUNC_MARK_ALL, 10'd512);
    queue_beat(FUNC_SAMPLE, 8'd100, 32'h0040_5060, 1'b1, '0);
    // clear mid-tile restarts the hash and empties the store
    queue_beat(FUNC_SAMPLE, 8'd0, 32'h0077_7777, 1'b0, '0);
    queue_cmd(FUNC_CLEAR, 10'd256);
    queue_beat(FUNC_SAMPLE, 8'd0, 32'h0000_0000, 1'b1, '0);
    queue_beat(FUNC_SAMPLE, 8'd15, 32'h8000_0001, 1'b1, '0);
  endtask

  task automatic build_random();
    int useful;
    int pick;
    int n;
    int ver;
    logic [7:0]  tile;
    logic [31:0] px;
    useful = 0;
    while (useful < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        // one whole tile; patterns 0 and 1 repeat so that hashes can match
        tile = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) :
                                             8'($urandom_range(0, NUM_TILES - 1));
        n = $urandom_range(1, 6);
        ver = $urandom_range(0, 2);
        for (int k = 0; k < n; k++) begin
          px = (ver == 2) ? $urandom : {tile, 8'(k), 8'(ver), 8'h5A};
          queue_beat(FUNC_SAMPLE, tile, px, 1'(k == n - 1), 10'($urandom));
          useful++;
        end
      end else if (pick < 84) begin
        queue_cmd(FUNC_TRIM, 10'($urandom_range(0, 768)));
        useful++;
      end else if (pick < 87) begin
        queue_cmd(FUNC_MARK_ALL, 10'($urandom_range(0, 768)));
        useful++;
      end else if (pick < 89) begin
        queue_cmd(FUNC_CLEAR, 10'($urandom_range(0, 768)));
        useful++;
      end else begin
        // stray sample: may break a tile open or fall off the screen
        tile = 8'($urandom_range(0, 255));
        queue_beat(FUNC_SAMPLE, tile, $urandom, 1'($urandom), 10'($urandom_range(0, 768)));
        if (tile < NUM_TILES) useful++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: new beat at the falling edge once the slot is free
  // ---------------------------------------------------------------------------

  function automatic logic calm();
    return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      // a held beat stays put until taken
      if (!in_valid || in_fire) begin
        if (beat_plan.size() != 0 && (calm() || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_data <= beat_plan.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !calm() && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      // results only come from earlier beats, so check before predicting
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) begin
        fold_beat(in_data);
        beats_taken <= beats_taken + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               digest_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    in_fire = 1'b0;
    beats_taken = 0;
    mismatches = 0;
    cycle_count = 0;
    // predictor matches the block's reset state
    clear_store('0);
    fold_hash = FNV_BASIS;
    span_lo = '0;
    span_hi = '0;

    build_directed();
    build_random();
    beats_planned = beat_plan.size();

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // every beat taken and every owed result seen, then let the pipe settle
    while (beats_taken != beats_planned || digest_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digest_due.size() != 0)
      report_mismatch("results still owed, count", 32'(digest_due.size()), '0);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
